@@ rtl/acmac_kd_pkg.sv @@
// package for the cmac key diversifier: types, constants and aes helper functions
`timescale 1ns / 1ps
`default_nettype none
package acmac_kd_pkg;

   localparam int MaxDivBytes = 31;
   localparam logic [7:0] LeadByte = 8'h01;
   localparam logic [7:0] PadByte = 8'h80;
   localparam logic [7:0] RedConst = 8'h87;

   localparam logic [2:0] CsrKeyHigh = 3'd0;
   localparam logic [2:0] CsrKeyLow = 3'd1;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_LOAD,
      ST_ROUND,
      ST_NEXT,
      ST_OUT
   } state_type;

   // which of the three aes passes is running
   typedef enum logic [1:0] {
      PASS_SUBKEY,
      PASS_BLOCK1,
      PASS_BLOCK2
   } pass_type;

   localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xt(input logic [7:0] a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit block sits in bits 127-8i downto 120-8i
   function automatic logic [7:0] byte_of(input logic [127:0] v, input int i);
      byte_of = v[127 - 8 * i -: 8];
   endfunction

   // one aes round without the key add; last drops mixcolumns
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] r;
      for (int c = 0; c < 4; c++) begin
         for (int w = 0; w < 4; w++) begin
            t[w + 4 * c] = SBOX[byte_of(s, w + 4 * ((c + w) % 4))];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
         x = a0 ^ a1 ^ a2 ^ a3;
         if (!last) begin
            t[4 * c] = a0 ^ x ^ xt(a0 ^ a1);
            t[4 * c + 1] = a1 ^ x ^ xt(a1 ^ a2);
            t[4 * c + 2] = a2 ^ x ^ xt(a2 ^ a3);
            t[4 * c + 3] = a3 ^ x ^ xt(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8 * i -: 8] = t[i];
      end
      aes_round = r;
   endfunction

   // next round key from the current one
   function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      key_step = {w0, w1, w2, w3};
   endfunction

   function automatic logic [127:0] gf_double(input logic [127:0] k);
      gf_double = {k[126:0], 1'b0} ^ {120'd0, (k[127] ? RedConst : 8'h00)};
   endfunction

endpackage
`default_nettype wire

@@ rtl/aes128_cmac_key_diversifier.sv @@
// aes-128 cmac key diversifier: byte collection, shared aes round unit, sequencer
// bytes are taken back to back while collecting. after a last byte is taken, a load step and
// three aes-128 passes (10 rounds and a hand-over each) run before rsp_tvalid rises,
// through one shared round unit and key schedule.
// one transaction is worked at a time; req_tready is low from the last byte until the
// result is taken. overflowed messages raise rsp_tvalid in the cycle after the last byte.
// reset clears the sequencer, byte count, overflow flag and key registers; the buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module aes128_cmac_key_diversifier #(
   parameter int MAX_DIV_BYTES = acmac_kd_pkg::MaxDivBytes
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // div_byte
   input  wire logic         req_tlast,   // last_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,   // key_high [63:0], key_low [127:64]
   output logic              rsp_tuser,   // status
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);

   acmac_kd_pkg::state_type state_ff, state_in;
   acmac_kd_pkg::pass_type  pass_ff, pass_in;

   logic [63:0]  key_high_ff, key_low_ff;
   logic [7:0]   buf_ff [32];
   logic [5:0]   count_ff, count_in;
   logic         ovf_ff, ovf_in;
   logic [127:0] st_ff, st_in;
   logic [127:0] rk_ff, rk_in;
   logic [7:0]   rc_ff, rc_in;
   logic [3:0]   round_ff, round_in;
   logic [127:0] sub_ff, sub_in;
   logic [127:0] out_ff, out_in;
   logic         status_ff, status_in;
   logic [127:0] m1, m2;

   logic accept;
   logic [2:0] csr_sel;
   assign accept = req_tvalid && req_tready;
   assign csr_sel = csr_paddr[3:3] == 1'b0 ? acmac_kd_pkg::CsrKeyHigh : acmac_kd_pkg::CsrKeyLow;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] ? key_low_ff : key_high_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_sel)
            acmac_kd_pkg::CsrKeyHigh: key_high_ff <= csr_pwdata;
            acmac_kd_pkg::CsrKeyLow:  key_low_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // message buffer: entry 0 is the lead byte, written alongside
   always_ff @(posedge clock) begin
      buf_ff[0] <= acmac_kd_pkg::LeadByte;
      if (accept && count_ff < 6'(MAX_DIV_BYTES)) begin
         buf_ff[5'(count_ff + 6'd1)] <= req_tdata;
      end
   end

   // padded two-block message: pad byte after the last byte if it fits, bytes beyond it zero
   always_comb begin
      logic [7:0] b;
      for (int i = 0; i < 32; i++) begin
         if (i <= int'(count_ff)) b = buf_ff[i];
         else if (i == int'(count_ff) + 1 && count_ff < 6'(MAX_DIV_BYTES)) b = acmac_kd_pkg::PadByte;
         else b = 8'h00;
         if (i < 16) m1[127 - 8 * i -: 8] = b;
         else m2[127 - 8 * (i - 16) -: 8] = b;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         acmac_kd_pkg::ST_COLLECT: if (accept && req_tlast) begin
            state_in = (ovf_ff || count_ff >= 6'(MAX_DIV_BYTES)) ? acmac_kd_pkg::ST_OUT
                                                                 : acmac_kd_pkg::ST_LOAD;
         end
         acmac_kd_pkg::ST_LOAD:  state_in = acmac_kd_pkg::ST_ROUND;
         acmac_kd_pkg::ST_ROUND: if (round_ff == 4'd10) state_in = acmac_kd_pkg::ST_NEXT;
         acmac_kd_pkg::ST_NEXT:  state_in = (pass_ff == acmac_kd_pkg::PASS_BLOCK2)
                                            ? acmac_kd_pkg::ST_OUT : acmac_kd_pkg::ST_ROUND;
         acmac_kd_pkg::ST_OUT:   if (rsp_tready) state_in = acmac_kd_pkg::ST_COLLECT;
         default: state_in = acmac_kd_pkg::ST_COLLECT;
      endcase
   end

   always_comb begin
      logic [127:0] kd;
      pass_in = pass_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      st_in = st_ff;
      rk_in = rk_ff;
      rc_in = rc_ff;
      round_in = round_ff;
      sub_in = sub_ff;
      out_in = out_ff;
      status_in = status_ff;
      kd = '0;
      case (state_ff)
         acmac_kd_pkg::ST_COLLECT: if (accept) begin
            if (count_ff < 6'(MAX_DIV_BYTES)) count_in = count_ff + 6'd1;
            else ovf_in = 1'b1;
            if (req_tlast && (ovf_ff || count_ff >= 6'(MAX_DIV_BYTES))) begin
               out_in = '0;
               status_in = 1'b1;
            end
         end
         acmac_kd_pkg::ST_LOAD: begin
            pass_in = acmac_kd_pkg::PASS_SUBKEY;
            rk_in = {key_high_ff, key_low_ff};
            st_in = {key_high_ff, key_low_ff};
            rc_in = 8'h01;
            round_in = 4'd1;
         end
         acmac_kd_pkg::ST_ROUND: begin
            // one round and one key-schedule step per cycle
            kd = acmac_kd_pkg::key_step(rk_ff, rc_ff);
            st_in = acmac_kd_pkg::aes_round(st_ff, round_ff == 4'd10) ^ kd;
            rk_in = kd;
            rc_in = acmac_kd_pkg::xt(rc_ff);
            round_in = round_ff + 4'd1;
         end
         acmac_kd_pkg::ST_NEXT: begin
            rk_in = {key_high_ff, key_low_ff};
            rc_in = 8'h01;
            round_in = 4'd1;
            case (pass_ff)
               acmac_kd_pkg::PASS_SUBKEY: begin
                  kd = acmac_kd_pkg::gf_double(st_ff);
                  if (count_ff < 6'(MAX_DIV_BYTES)) kd = acmac_kd_pkg::gf_double(kd);
                  sub_in = kd;
                  st_in = m1 ^ {key_high_ff, key_low_ff};
                  pass_in = acmac_kd_pkg::PASS_BLOCK1;
               end
               acmac_kd_pkg::PASS_BLOCK1: begin
                  st_in = st_ff ^ m2 ^ sub_ff ^ {key_high_ff, key_low_ff};
                  pass_in = acmac_kd_pkg::PASS_BLOCK2;
               end
               default: begin
                  out_in = st_ff;
                  status_in = 1'b0;
               end
            endcase
         end
         acmac_kd_pkg::ST_OUT: if (rsp_tready) begin
            count_in = '0;
            ovf_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acmac_kd_pkg::ST_COLLECT;
         pass_ff <= acmac_kd_pkg::PASS_SUBKEY;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         st_ff <= '0;
         rk_ff <= '0;
         rc_ff <= '0;
         round_ff <= '0;
         sub_ff <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff <= pass_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         st_ff <= st_in;
         rk_ff <= rk_in;
         rc_ff <= rc_in;
         round_ff <= round_in;
         sub_ff <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      status_ff <= status_in;
   end

   always_comb begin
      req_tready = (state_ff == acmac_kd_pkg::ST_COLLECT);
      rsp_tvalid = (state_ff == acmac_kd_pkg::ST_OUT);
      rsp_tdata = {out_ff[63:0], out_ff[127:64]};
      rsp_tuser = status_ff;
   end

endmodule
`default_nettype wire

@@ test/tb_aes128_cmac_key_diversifier.sv @@
// testbench for the aes-128 cmac key diversifier: directed table, random messages, scoreboard
`timescale 1ns / 1ps
module tb_aes128_cmac_key_diversifier;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0, req_tlast = 1'b0;
   logic [7:0] req_tdata = '0;
   logic req_tready;
   logic rsp_tvalid, rsp_tuser;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   aes128_cmac_key_diversifier u_top (.*);

   typedef struct packed {
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic        status;
   } derived_key_type;

   typedef struct {
      logic [7:0] div_byte;
      logic       last_byte;
      logic       check_fixed;
      logic       fixed_status;
   } stim_row_type;

   derived_key_type key_queue [$];
   logic [63:0] mk_high = '0, mk_low = '0;
   logic [7:0] msg_bytes [32];
   int unsigned div_count = 0;
   logic div_overflow = 1'b0;
   int unsigned error_count = 0;
   int unsigned send_idle_pct = 0, recv_stall_pct = 0;
   int unsigned hold_off = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[aes128_cmac_key_diversifier] ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [127:0] got,
                                  input logic [127:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [127:0] round_key_next(input logic [127:0] k,
                                                   input logic [7:0] rc);
      logic [31:0] w [4];
      logic [31:0] t;
      logic [7:0] sb [4];
      for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
      sb[0] = acmac_kd_pkg::SBOX[w[3][23:16]]; sb[1] = acmac_kd_pkg::SBOX[w[3][15:8]];
      sb[2] = acmac_kd_pkg::SBOX[w[3][7:0]];   sb[3] = acmac_kd_pkg::SBOX[w[3][31:24]];
      t = {sb[0] ^ rc, sb[1], sb[2], sb[3]};
      w[0] = w[0] ^ t;
      for (int i = 1; i < 4; i++) w[i] = w[i] ^ w[i - 1];
      return {w[0], w[1], w[2], w[3]};
   endfunction

   function automatic logic [7:0] mul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                input logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x, rc;
      logic [127:0] k, r;
      k = key;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ k[127 - 8 * i -: 8];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               t[w + 4 * c] = acmac_kd_pkg::SBOX[s[w + 4 * ((c + w) & 3)]];
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
               x = a0 ^ a1 ^ a2 ^ a3;
               t[4 * c] = a0 ^ x ^ mul2(a0 ^ a1);
               t[4 * c + 1] = a1 ^ x ^ mul2(a1 ^ a2);
               t[4 * c + 2] = a2 ^ x ^ mul2(a2 ^ a3);
               t[4 * c + 3] = a3 ^ x ^ mul2(a3 ^ a0);
            end
         end
         k = round_key_next(k, rc);
         rc = mul2(rc);
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ k[127 - 8 * i -: 8];
      end
      for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
      return r;
   endfunction

   function automatic logic [127:0] gf_times_x(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
   endfunction

   // derivation of the key from the collected bytes
   task automatic collect_byte(input logic [7:0] b, input logic last);
      logic [127:0] key, sub, blk1, blk2;
      logic [255:0] msg;
      derived_key_type res;
      if (div_count < acmac_kd_pkg::MaxDivBytes) begin
         msg_bytes[div_count + 1] = b;
         div_count++;
      end else begin
         div_overflow = 1'b1;
      end
      if (!last) return;
      if (div_overflow) begin
         res = '{key_high: '0, key_low: '0, status: 1'b1};
      end else begin
         key = {mk_high, mk_low};
         sub = gf_times_x(aes_encrypt(key, '0));
         msg = '0;
         msg[255 -: 8] = acmac_kd_pkg::LeadByte;
         for (int i = 1; i <= div_count; i++) msg[255 - 8 * i -: 8] = msg_bytes[i];
         if (div_count < acmac_kd_pkg::MaxDivBytes) begin
            msg[255 - 8 * (div_count + 1) -: 8] = acmac_kd_pkg::PadByte;
            sub = gf_times_x(sub);
         end
         blk1 = aes_encrypt(key, msg[255:128]);
         blk2 = aes_encrypt(key, blk1 ^ msg[127:0] ^ sub);
         res = '{key_high: blk2[127:64], key_low: blk2[63:0], status: 1'b0};
      end
      key_queue.push_back(res);
      div_count = 0;
      div_overflow = 1'b0;
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic set_master_key(input logic [63:0] hi, input logic [63:0] lo);
      csr_write(4'(acmac_kd_pkg::CsrKeyHigh) << 3, hi);
      csr_write(4'(acmac_kd_pkg::CsrKeyLow) << 3, lo);
      mk_high = hi;
      mk_low = lo;
   endtask

   // valid stays high into the next call so bytes can follow back to back
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1; req_tdata <= b; req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      collect_byte(b, last);
      @(negedge clock);
   endtask

   task automatic send_message(input int unsigned len);
      for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
   endtask

   task automatic drain();
      int unsigned guard = 0;
      req_tvalid <= 1'b0;
      while (key_queue.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (60) @(negedge clock);
   endtask

   // receiver: random stalls plus an optional long hold-off
   always @(negedge clock) begin
      if (hold_off != 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      derived_key_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (key_queue.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, '0);
         end else begin
            want = key_queue.pop_front();
            if (rsp_tdata[63:0] !== want.key_high)
               report_mismatch("key_high", 128'(rsp_tdata[63:0]), 128'(want.key_high));
            if (rsp_tdata[127:64] !== want.key_low)
               report_mismatch("key_low", 128'(rsp_tdata[127:64]), 128'(want.key_low));
            if (rsp_tuser !== want.status)
               report_mismatch("status", 128'(rsp_tuser), 128'(want.status));
         end
      end
   end

   stim_row_type directed [$];

   initial begin
      int unsigned items;
      int unsigned len;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero key after reset: short, empty-ish, full and overflowing messages
      directed.push_back('{8'h00, 1'b1, 1'b0, 1'b0});
      directed.push_back('{8'hff, 1'b1, 1'b0, 1'b0});
      for (int i = 0; i < 31; i++)
         directed.push_back('{(i[0] ? 8'hff : 8'h00), i == 30, 1'b0, 1'b0});
      for (int i = 0; i < 32; i++)
         directed.push_back('{8'h5a, i == 31, i == 31, 1'b1});
      directed.push_back('{8'h80, 1'b0, 1'b0, 1'b0});
      directed.push_back('{8'h7f, 1'b1, 1'b0, 1'b0});
      foreach (directed[i]) begin
         send_byte(directed[i].div_byte, directed[i].last_byte);
         if (directed[i].check_fixed && key_queue[$].status !== directed[i].fixed_status)
            report_mismatch("fixed status", 128'(key_queue[$].status),
                            128'(directed[i].fixed_status));
      end
      drain();

      items = 0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin set_master_key('1, '1); send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin set_master_key({$urandom, $urandom}, {$urandom, $urandom});
               send_idle_pct = 59; recv_stall_pct = 0; end
            2: begin set_master_key({$urandom, $urandom}, {$urandom, $urandom});
               send_idle_pct = 0; recv_stall_pct = 59; end
            3: begin set_master_key({$urandom, $urandom}, '0);
               send_idle_pct = 21; recv_stall_pct = 21; end
            4: begin set_master_key(64'h8000_0000_0000_0000, 64'h1);
               send_idle_pct = 0; recv_stall_pct = 0; end
            default: begin set_master_key({$urandom, $urandom}, {$urandom, $urandom});
               send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (phase == 4) hold_off = 400;
         for (int m = 0; m < 14; m++) begin
            case ($urandom_range(9))
               0: len = 31;
               1: len = $urandom_range(32, 40);
               default: len = $urandom_range(1, 30);
            endcase
            send_message(len);
            items += len;
         end
         drain();
      end
      if (error_count == 0 && key_queue.size() == 0) begin
         $display("[aes128_cmac_key_diversifier] OK");
      end else begin
         $display("[aes128_cmac_key_diversifier] ERROR");
      end
      $finish;
   end
endmodule
